/* rtl/fralloc_pkg.sv */
// ----------------------------------------------------------------------------
// fralloc_pkg
// shared widths, register indexes, controller states and command structs
// for the round-robin frame allocator
// ----------------------------------------------------------------------------
package fralloc_pkg;

   localparam int FRAMES_DEF       = 64;
   localparam int SPF_DEF          = 8;
   localparam int FRAME_BYTES_DEF  = 4096;

   localparam int OWNER_W  = 8;
   localparam int PAGE_W   = 20;
   localparam int SECTOR_W = 32;
   localparam int LEN_W    = 24;
   localparam int COUNT_W  = 4;
   localparam int INDEX_W  = 6;
   localparam int ADDR_W   = 32;

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 144;
   localparam int RSP_USER_W = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_FRAME_BASE = 1'b0;
   localparam logic REG_START_PAGE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic pick;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [OWNER_W-1:0]  owner;
      logic [PAGE_W-1:0]   page;
      logic [SECTOR_W-1:0] start;
      logic [LEN_W-1:0]    len;
      logic [COUNT_W-1:0]  rem;
   } frame_meta_type;

endpackage

/* rtl/fralloc_csr.sv */
// ----------------------------------------------------------------------------
// fralloc_csr
// configuration registers: frame base address and process start page
// ----------------------------------------------------------------------------
module fralloc_csr
   import fralloc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [ADDR_W-1:0]     frame_base,
   output logic [PAGE_W-1:0]     process_start_page
);

   logic [ADDR_W-1:0] frame_base_ff;
   logic [PAGE_W-1:0] start_page_ff;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         start_page_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_FRAME_BASE: frame_base_ff <= csr_pwdata;
            REG_START_PAGE: start_page_ff <= csr_pwdata[PAGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FRAME_BASE: csr_prdata = frame_base_ff;
         REG_START_PAGE: csr_prdata = CSR_DATA_W'(start_page_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign frame_base         = frame_base_ff;
   assign process_start_page = start_page_ff;

endmodule

/* rtl/fralloc_ctrl.sv */
// ----------------------------------------------------------------------------
// fralloc_ctrl
// request sequencer: accept, pick a frame, write back metadata and respond
// ----------------------------------------------------------------------------
module fralloc_ctrl
   import fralloc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/fralloc_dpath.sv */
// ----------------------------------------------------------------------------
// fralloc_dpath
// frame selection, pin bits, metadata memory, sector spans and response
// register
// ----------------------------------------------------------------------------
module fralloc_dpath
   import fralloc_pkg::*;
#(
   parameter int FRAMES            = FRAMES_DEF,
   parameter int SECTORS_PER_FRAME = SPF_DEF,
   parameter int FRAME_BYTES       = FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [ADDR_W-1:0]     frame_base,
   input  logic [PAGE_W-1:0]     process_start_page,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int IW        = $clog2(FRAMES);
   localparam int CW        = IW + 1;
   localparam int REL_W     = PAGE_W + 7;
   localparam int RCP_SHIFT = 31;
   localparam int RCP_W     = 32;
   localparam int PROD_W    = LEN_W + RCP_W;
   localparam logic [RCP_W-1:0] RECIP =
      RCP_W'((64'd1 << RCP_SHIFT) / SECTORS_PER_FRAME + 1);

   // request fields
   logic                 in_pin_ff;
   logic [OWNER_W-1:0]   in_owner_ff;
   logic [PAGE_W-1:0]    in_page_ff;
   logic [SECTOR_W-1:0]  in_start_ff;
   logic [LEN_W-1:0]     in_len_ff;

   // allocation state
   logic [CW-1:0]        fresh_count_ff;
   logic [IW-1:0]        last_victim_ff;
   logic [FRAMES-1:0]    pinned_ff;

   // pick results
   logic [IW-1:0]        idx_ff;
   logic                 fresh_ff;
   logic                 none_ff;
   logic [LEN_W-1:0]     quot_ff;
   logic [SECTOR_W-1:0]  load_sector_ff;
   logic                 load_clip_ff;

   frame_meta_type       meta_mem [FRAMES];
   frame_meta_type       meta_rd_ff;

   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;

   logic [FRAMES-1:0]    avail;
   logic [FRAMES-1:0]    above;
   logic [FRAMES-1:0]    hi_avail;
   logic [IW-1:0]        cand;
   logic                 found;
   logic                 is_fresh;
   logic [IW-1:0]        idx_sel;
   logic [PROD_W-1:0]    prod;
   logic [REL_W-1:0]     load_rel;
   logic [LEN_W-1:0]     rem_full;
   logic [COUNT_W-1:0]   rem;
   frame_meta_type       new_meta;
   logic [COUNT_W-1:0]   load_count;
   logic [REL_W-1:0]     vic_rel;
   logic                 vic_clip;
   logic [SECTOR_W-1:0]  vic_sector;
   logic [COUNT_W-1:0]   vic_count;
   logic [ADDR_W-1:0]    frame_addr;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_in;

   function automatic logic [IW-1:0] lowest_set(input logic [FRAMES-1:0] vec);
      logic [IW-1:0] pos;
      pos = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (vec[i]) pos = IW'(i);
      end
      return pos;
   endfunction

   function automatic logic [REL_W-1:0] rel_of(input logic [PAGE_W-1:0] page,
                                                input logic [PAGE_W-1:0] base);
      logic [PAGE_W-1:0] off;
      off = page - base;
      return REL_W'(REL_W'(off) * REL_W'(SECTORS_PER_FRAME));
   endfunction

   function automatic logic clip_of(input logic [REL_W-1:0] rel,
                                    input logic [LEN_W-1:0] len);
      return ((REL_W+1)'(rel) + (REL_W+1)'(SECTORS_PER_FRAME)) > (REL_W+1)'(len);
   endfunction

   // rotating search for the first unpinned frame after the last victim
   always_comb begin
      avail = ~pinned_ff;
      for (int i = 0; i < FRAMES; i++) begin
         above[i] = IW'(i) > last_victim_ff;
      end
      hi_avail = avail & above;
      cand     = (|hi_avail) ? lowest_set(hi_avail) : lowest_set(avail);
      found    = |avail;
      is_fresh = fresh_count_ff < CW'(FRAMES);
      idx_sel  = is_fresh ? fresh_count_ff[IW-1:0] : cand;
   end

   assign prod     = PROD_W'(in_len_ff) * PROD_W'(RECIP);
   assign load_rel = rel_of(in_page_ff, process_start_page);

   // image length modulo sectors per frame
   assign rem_full = in_len_ff - LEN_W'(quot_ff * LEN_W'(SECTORS_PER_FRAME));
   assign rem      = COUNT_W'(rem_full);

   assign new_meta.owner = in_owner_ff;
   assign new_meta.page  = in_page_ff;
   assign new_meta.start = in_start_ff;
   assign new_meta.len   = in_len_ff;
   assign new_meta.rem   = rem;

   assign load_count = load_clip_ff ? rem : COUNT_W'(SECTORS_PER_FRAME);

   assign vic_rel    = rel_of(meta_rd_ff.page, process_start_page);
   assign vic_clip   = clip_of(vic_rel, meta_rd_ff.len);
   assign vic_sector = meta_rd_ff.start + SECTOR_W'(vic_rel);
   assign vic_count  = vic_clip ? meta_rd_ff.rem : COUNT_W'(SECTORS_PER_FRAME);

   assign frame_addr = frame_base + ADDR_W'(ADDR_W'(idx_ff) * ADDR_W'(FRAME_BYTES));

   always_comb begin
      if (none_ff) begin
         rsp_data_in = '0;
         rsp_user_in = 2'b01;
      end else if (fresh_ff) begin
         rsp_data_in = RSP_DATA_W'({load_count, load_sector_ff, COUNT_W'(0),
                                    SECTOR_W'(0), PAGE_W'(0), OWNER_W'(0),
                                    frame_addr, INDEX_W'(idx_ff)});
         rsp_user_in = 2'b00;
      end else begin
         rsp_data_in = RSP_DATA_W'({load_count, load_sector_ff, vic_count,
                                    vic_sector, meta_rd_ff.page, meta_rd_ff.owner,
                                    frame_addr, INDEX_W'(idx_ff)});
         rsp_user_in = 2'b10;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_count_ff <= '0;
         last_victim_ff <= IW'(FRAMES - 1);
         pinned_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.pick) begin
            if (is_fresh) begin
               fresh_count_ff     <= fresh_count_ff + CW'(1);
               pinned_ff[idx_sel] <= in_pin_ff;
            end else if (found) begin
               last_victim_ff     <= cand;
               pinned_ff[idx_sel] <= in_pin_ff;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_owner_ff <= req_tdata[7:0];
         in_page_ff  <= req_tdata[27:8];
         in_start_ff <= req_tdata[59:28];
         in_len_ff   <= req_tdata[83:60];
         in_pin_ff   <= req_tuser[0];
      end
      if (cmd.pick) begin
         idx_ff         <= idx_sel;
         fresh_ff       <= is_fresh;
         none_ff        <= !is_fresh && !found;
         quot_ff        <= prod[RCP_SHIFT +: LEN_W];
         load_sector_ff <= in_start_ff + SECTOR_W'(load_rel);
         load_clip_ff   <= clip_of(load_rel, in_len_ff);
      end
      if (cmd.finish) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // metadata memory
   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         meta_rd_ff <= meta_mem[idx_sel];
      end
      if (cmd.finish && !none_ff) begin
         meta_mem[idx_ff] <= new_meta;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;

endmodule

/* rtl/frame_allocator_round_robin_evict.sv */
// ----------------------------------------------------------------------------
// frame_allocator_round_robin_evict
// page frame allocator: fresh frames in order, then round-robin eviction of
// unpinned frames, with write-back and load sector spans
// ----------------------------------------------------------------------------
// each request passes accept, frame pick with metadata memory read, then
// metadata write and response load; a full response register stalls the
// last step, and no new request is accepted until the response load
// reset: pin bits, fresh count, csr registers and all control cleared at
//   once, last victim set to the last frame; metadata memory is not
//   cleared, no clearing pass
// ----------------------------------------------------------------------------
module frame_allocator_round_robin_evict
   import fralloc_pkg::*;
#(
   parameter int FRAMES            = FRAMES_DEF,
   parameter int SECTORS_PER_FRAME = SPF_DEF,
   parameter int FRAME_BYTES       = FRAME_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // owner_id, page_number, image_start_sector, image_sectors, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // pin_frame
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // frame_index, frame_address, victim_owner, victim_page_number,
   // victim_sector, victim_sector_count, load_sector, load_sector_count, pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // all_pinned, evicted
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [ADDR_W-1:0] frame_base;
   logic [PAGE_W-1:0] process_start_page;

   fralloc_csr u_csr (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .frame_base         (frame_base),
      .process_start_page (process_start_page)
   );

   fralloc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fralloc_dpath #(
      .FRAMES            (FRAMES),
      .SECTORS_PER_FRAME (SECTORS_PER_FRAME),
      .FRAME_BYTES       (FRAME_BYTES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .frame_base         (frame_base),
      .process_start_page (process_start_page),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("response loaded while response register full");

   a_accept_then_pick: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.pick)
      else $error("accepted request not followed by frame pick");

   a_busy_after_pick: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |=> !req_tready)
      else $error("request accepted before metadata write back");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.pick, cmd.finish}))
      else $error("more than one datapath command at once");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the round-robin frame allocator: requests are
// streamed in under random sender and receiver stalls, every response is
// compared field by field against an in-bench model of fresh grants,
// round-robin eviction, pinning and sector spans, across several base and
// start page settings, ending with every frame pinned
// ----------------------------------------------------------------------------
module tb;
   import fralloc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT      = 400000;
   localparam int PIN_BUDGET = 60;

   typedef struct packed {
      logic                pin;
      logic [OWNER_W-1:0]  owner;
      logic [PAGE_W-1:0]   page;
      logic [SECTOR_W-1:0] start;
      logic [LEN_W-1:0]    len;
   } frame_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [ADDR_W-1:0]   address;
      logic                all_pinned;
      logic                evicted;
      logic [OWNER_W-1:0]  victim_owner;
      logic [PAGE_W-1:0]   victim_page;
      logic [SECTOR_W-1:0] victim_sector;
      logic [COUNT_W-1:0]  victim_count;
      logic [SECTOR_W-1:0] load_sector;
      logic [COUNT_W-1:0]  load_count;
   } alloc_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_req_type    pending_reqs[$];
   alloc_result_type grant_q[$];
   frame_req_type    cur_req;
   int            req_sent = 0;
   int            req_done = 0;
   int            send_idle = 0;
   int            recv_idle = 0;
   int            errors = 0;
   int            cycles = 0;
   int            pins_used = 0;
   int            n_results = 0;
   int            n_evicted = 0;
   int            n_refused = 0;
   int            n_settings = 0;

   // allocator model state
   logic [ADDR_W-1:0]   frame_base_cfg = '0;
   logic [PAGE_W-1:0]   start_page_cfg = '0;
   int                  fresh_cnt = 0;
   int                  last_vic = FRAMES_DEF - 1;
   bit                  pinned[FRAMES_DEF];
   logic [OWNER_W-1:0]  meta_owner[FRAMES_DEF];
   logic [PAGE_W-1:0]   meta_page[FRAMES_DEF];
   logic [SECTOR_W-1:0] meta_start[FRAMES_DEF];
   logic [LEN_W-1:0]    meta_len[FRAMES_DEF];

   frame_allocator_round_robin_evict u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic logic [SECTOR_W-1:0] span_sector(logic [PAGE_W-1:0] pg,
                                                        logic [SECTOR_W-1:0] st);
      logic [PAGE_W-1:0] off;
      off = pg - start_page_cfg;
      return SECTOR_W'(st + SECTOR_W'(off) * SECTOR_W'(SPF_DEF));
   endfunction

   function automatic logic [COUNT_W-1:0] span_count(logic [PAGE_W-1:0] pg,
                                                      logic [LEN_W-1:0] len);
      logic [PAGE_W-1:0] off;
      logic [31:0]       rel;
      off = pg - start_page_cfg;
      rel = 32'(off) * 32'(SPF_DEF);
      if (rel + 32'(SPF_DEF) > 32'(len)) begin
         return COUNT_W'(32'(len) % 32'(SPF_DEF));
      end
      return COUNT_W'(SPF_DEF);
   endfunction

   function automatic alloc_result_type grant_frame(frame_req_type r);
      alloc_result_type res;
      int            idx;
      int            cand;
      bit            found;
      res = '0;
      idx = 0;
      found = 1'b0;
      if (fresh_cnt < FRAMES_DEF) begin
         idx = fresh_cnt;
         fresh_cnt++;
         found = 1'b1;
      end else begin
         cand = last_vic;
         for (int n = 0; n < FRAMES_DEF; n++) begin
            cand = (cand + 1) % FRAMES_DEF;
            if (!pinned[cand]) begin
               found = 1'b1;
               break;
            end
         end
         if (found) begin
            idx = cand;
            last_vic = cand;
            res.evicted = 1'b1;
            res.victim_owner = meta_owner[idx];
            res.victim_page = meta_page[idx];
            res.victim_sector = span_sector(meta_page[idx], meta_start[idx]);
            res.victim_count = span_count(meta_page[idx], meta_len[idx]);
         end
      end
      if (!found) begin
         res.all_pinned = 1'b1;
         return res;
      end
      pinned[idx] = r.pin;
      meta_owner[idx] = r.owner;
      meta_page[idx] = r.page;
      meta_start[idx] = r.start;
      meta_len[idx] = r.len;
      res.index = INDEX_W'(idx);
      res.address = ADDR_W'(frame_base_cfg + ADDR_W'(idx) * ADDR_W'(FRAME_BYTES_DEF));
      res.load_sector = span_sector(r.page, r.start);
      res.load_count = span_count(r.page, r.len);
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_done == req_sent)) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= {4'b0, cur_req.len, cur_req.start, cur_req.page, cur_req.owner};
            req_tuser <= cur_req.pin;
            req_tvalid <= 1'b1;
            req_sent <= req_sent + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   // request prediction and response check
   always @(posedge clock) begin : monitor
      alloc_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            grant_q.push_back(grant_frame(cur_req));
            req_done <= req_done + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (grant_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = grant_q.pop_front();
               check_field("frame_index", 32'(want.index), 32'(rsp_tdata[5:0]));
               check_field("frame_address", want.address, rsp_tdata[37:6]);
               check_field("all_pinned", 32'(want.all_pinned), 32'(rsp_tuser[0]));
               check_field("evicted", 32'(want.evicted), 32'(rsp_tuser[1]));
               check_field("victim_owner", 32'(want.victim_owner), 32'(rsp_tdata[45:38]));
               check_field("victim_page_number", 32'(want.victim_page),
                           32'(rsp_tdata[65:46]));
               check_field("victim_sector", want.victim_sector, rsp_tdata[97:66]);
               check_field("victim_sector_count", 32'(want.victim_count),
                           32'(rsp_tdata[101:98]));
               check_field("load_sector", want.load_sector, rsp_tdata[133:102]);
               check_field("load_sector_count", 32'(want.load_count),
                           32'(rsp_tdata[137:134]));
               n_results++;
               if (want.evicted) n_evicted++;
               if (want.all_pinned) n_refused++;
            end
         end
      end
   end

   task automatic csr_access(logic wr, logic reg_sel, logic [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_ADDR_W'({reg_sel, 2'b00});
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (!wr && csr_prdata !== val) begin
         $error("csr readback: expected %0h, got %0h", val, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(logic [31:0] base, logic [31:0] spage);
      csr_access(1'b1, REG_FRAME_BASE, base);
      csr_access(1'b1, REG_START_PAGE, spage);
      frame_base_cfg = base;
      start_page_cfg = spage[PAGE_W-1:0];
      csr_access(1'b0, REG_FRAME_BASE, base);
      csr_access(1'b0, REG_START_PAGE, 32'(spage[PAGE_W-1:0]));
      n_settings++;
   endtask

   task automatic push_req(logic pin, logic [7:0] owner, logic [19:0] page,
                           logic [31:0] start, logic [23:0] len);
      frame_req_type r;
      r = '{pin, owner, page, start, len};
      if (pin) pins_used++;
      pending_reqs.push_back(r);
   endtask

   task automatic random_reqs(int count);
      logic        pin;
      logic [19:0] page;
      logic [23:0] len;
      int          off;
      for (int i = 0; i < count; i++) begin
         pin = (pins_used < PIN_BUDGET) && ($urandom_range(31) == 0);
         page = 20'($urandom);
         len = 24'($urandom);
         // pages near the image start so the end-of-image clip is exercised
         if ($urandom_range(99) < 60) begin
            off = $urandom_range(15);
            page = start_page_cfg + 20'(off);
            len = 24'(off * SPF_DEF + $urandom_range(16)) - 24'($urandom_range(8));
         end
         push_req(pin, 8'($urandom), page, $urandom, len);
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || grant_q.size() != 0 || req_tvalid) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 15;
      recv_idle = 48;
      configure(32'hFFFF_F000, 32'h0);
      push_req(1'b0, 8'h00, 20'h00000, 32'h0000_0000, 24'h000000);
      push_req(1'b1, 8'hFF, 20'hFFFFF, 32'hFFFF_FFFF, 24'hFFFFFF);
      push_req(1'b0, 8'h01, 20'h00000, 32'h0000_0010, 24'h000008);
      push_req(1'b0, 8'h02, 20'h00000, 32'h0000_0020, 24'h000007);
      push_req(1'b0, 8'h03, 20'h00001, 32'h0000_0030, 24'h00000F);
      push_req(1'b0, 8'h04, 20'h00001, 32'h0000_0040, 24'h000010);
      push_req(1'b0, 8'h05, 20'h00001, 32'h0000_0050, 24'h000011);
      push_req(1'b0, 8'h06, 20'h00002, 32'h0000_0060, 24'h000017);
      push_req(1'b0, 8'h07, 20'h00002, 32'h0000_0070, 24'h000014);
      push_req(1'b0, 8'h08, 20'hFFFFF, 32'h8000_0000, 24'h7FFFFF);
      push_req(1'b1, 8'hAA, 20'hAAAAA, 32'hAAAA_AAAA, 24'hAAAAAA);
      push_req(1'b0, 8'h55, 20'h55555, 32'h5555_5555, 24'h555555);
      push_req(1'b0, 8'h80, 20'h80000, 32'hFFFF_FFF8, 24'h800000);
      push_req(1'b0, 8'h7F, 20'h7FFFF, 32'h7FFF_FFFF, 24'h000001);
      random_reqs(150);
      drain();

      configure(32'h0, 32'hFFFF_FFFF);
      random_reqs(500);
      drain();

      send_idle = 48;
      recv_idle = 15;
      configure(32'hFFFF_FFFF, $urandom);
      random_reqs(550);
      drain();

      send_idle = 0;
      recv_idle = 0;
      configure($urandom, $urandom_range(15));
      random_reqs(560);
      // pin every remaining frame, then ask again with nothing left to evict
      while (pins_used < FRAMES_DEF) begin
         push_req(1'b1, 8'($urandom), 20'($urandom), $urandom, 24'($urandom));
      end
      repeat (4) begin
         push_req(1'($urandom_range(1)), 8'($urandom), 20'($urandom), $urandom,
                  24'($urandom));
      end
      drain();

      $display("checked %0d responses over %0d register settings", n_results, n_settings);
      $display("%0d grants came from eviction, %0d refused with every frame pinned",
               n_evicted, n_refused);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
